FILE: rtl/real_fft_512_fixed_point_core_defines.svh
// Assertion macros shared by the real FFT core RTL.
// No dependencies.
`ifndef REAL_FFT_512_FIXED_POINT_CORE_DEFINES_SVH
`define REAL_FFT_512_FIXED_POINT_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define RFFT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication outside reset.
`define RFFT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/rfft_pkg.sv
// Package for the real FFT core: widths, opcodes, sine table, Q15 helpers.
// No dependencies.
package rfft_pkg;
    localparam int SampleBits = 16;
    localparam int AddrBits   = 8;
    localparam int Words      = 256;
    localparam int Log2Points = 9;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_XFORM = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef logic signed [SampleBits-1:0] sample_t;

    function automatic logic [14:0] qsine(input logic [7:0] p);
        logic [14:0] t [0:128];
        t = '{15'd0,15'd402,15'd804,15'd1206,15'd1607,15'd2009,15'd2410,15'd2811,
              15'd3211,15'd3611,15'd4011,15'd4409,15'd4807,15'd5205,15'd5601,15'd5997,
              15'd6392,15'd6786,15'd7179,15'd7571,15'd7961,15'd8351,15'd8739,15'd9126,
              15'd9511,15'd9895,15'd10278,15'd10659,15'd11038,15'd11416,15'd11792,15'd12166,
              15'd12539,15'd12909,15'd13278,15'd13645,15'd14009,15'd14372,15'd14732,15'd15090,
              15'd15446,15'd15799,15'd16150,15'd16499,15'd16845,15'd17189,15'd17530,15'd17868,
              15'd18204,15'd18537,15'd18867,15'd19194,15'd19519,15'd19840,15'd20159,15'd20474,
              15'd20787,15'd21096,15'd21402,15'd21705,15'd22004,15'd22301,15'd22594,15'd22883,
              15'd23169,15'd23452,15'd23731,15'd24006,15'd24278,15'd24546,15'd24811,15'd25072,
              15'd25329,15'd25582,15'd25831,15'd26077,15'd26318,15'd26556,15'd26789,15'd27019,
              15'd27244,15'd27466,15'd27683,15'd27896,15'd28105,15'd28309,15'd28510,15'd28706,
              15'd28897,15'd29085,15'd29268,15'd29446,15'd29621,15'd29790,15'd29955,15'd30116,
              15'd30272,15'd30424,15'd30571,15'd30713,15'd30851,15'd30984,15'd31113,15'd31236,
              15'd31356,15'd31470,15'd31580,15'd31684,15'd31785,15'd31880,15'd31970,15'd32056,
              15'd32137,15'd32213,15'd32284,15'd32350,15'd32412,15'd32468,15'd32520,15'd32567,
              15'd32609,15'd32646,15'd32678,15'd32705,15'd32727,15'd32744,15'd32757,15'd32764,
              15'd32767};
        return (p > 8'd128) ? 15'd0 : t[p];
    endfunction

    // sin(2*pi*p/512) in Q15, p taken mod 512
    function automatic sample_t sine_at(input logic [8:0] p);
        logic [14:0] m;
        logic [8:0]  q;
        q = 9'd0;
        unique case (p[8:7])
            2'd0: q = p;
            2'd1: q = 9'd256 - p;
            2'd2: q = p - 9'd256;
            2'd3: q = 9'd0 - p;
            default: q = 9'd0;
        endcase
        if (p == 9'd128 || p == 9'd384)
            q = 9'd128;
        m = qsine(q[7:0]);
        return (p > 9'd256) ? -sample_t'({1'b0, m}) : sample_t'({1'b0, m});
    endfunction

    // (w*s+1)>>>15, wrapped
    function automatic sample_t qmul(input sample_t w, input sample_t s);
        logic signed [32:0] pr;
        pr = 33'(w * s) + 33'sd1;
        return sample_t'(pr >>> 15);
    endfunction
endpackage

FILE: rtl/real_fft_512_fixed_point_core.sv
// Top level of the 512-point real FFT core: sequencer and shared butterfly unit.
// Depends on rfft_pkg, rfft_ram and real_fft_512_fixed_point_core_defines.svh.
`include "real_fft_512_fixed_point_core_defines.svh"

// Issue a command with start while busy is low; every command yields one result
// transfer, flagged by done for one cycle, which cannot be stalled. A write goes
// straight to the done state; a read first passes the read-wait and output states
// for the registered RAM port; done rises as busy falls. A transform
// runs on one shared butterfly unit over the single-port sample RAM: a
// bit-reversal sweep (each word left in place is passed over, each of the 120
// swapped pairs is read and written back through states BA to BE), eight
// radix-2 passes of 128 butterflies and a 127-butterfly split pass, each
// butterfly stepping through two reads, operand capture, a spare step, products and two writes.
// done then reports shift_total = 9; reads and writes report 0.
module real_fft_512_fixed_point_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              opcode,
    input  logic [7:0]              word_index,
    input  rfft_pkg::sample_t       in_real,
    input  rfft_pkg::sample_t       in_imag,
    output logic                    done,
    output rfft_pkg::sample_t       out_real,
    output rfft_pkg::sample_t       out_imag,
    output logic [3:0]              shift_total
);
    import rfft_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;  // read wait
    localparam logic [3:0] S_RDO  = 4'd2;
    localparam logic [3:0] S_BA   = 4'd3;  // bitrev: read i
    localparam logic [3:0] S_BB   = 4'd4;  // read r, capture i
    localparam logic [3:0] S_BC   = 4'd5;  // hold r on the read port
    localparam logic [3:0] S_BD   = 4'd6;  // write r data to i
    localparam logic [3:0] S_BE   = 4'd7;  // write r
    localparam logic [3:0] S_FA   = 4'd8;  // butterfly: read a
    localparam logic [3:0] S_FB   = 4'd9;  // read b, capture a
    localparam logic [3:0] S_FC   = 4'd10; // capture b
    localparam logic [3:0] S_FD   = 4'd11; // spare
    localparam logic [3:0] S_FE   = 4'd12; // products
    localparam logic [3:0] S_FF   = 4'd13; // write a
    localparam logic [3:0] S_FG   = 4'd14; // write b
    localparam logic [3:0] S_DONE = 4'd15;

    logic [3:0] state_reg, state_next;
    logic [7:0] idx_reg, idx_next;     // bitrev index / butterfly counter
    logic [3:0] pass_reg, pass_next;   // 0..7 radix, 8 split
    logic [7:0] addr_reg, addr_next;
    sample_t    ar_reg, ai_reg, br_reg, bi_reg;
    sample_t    p1_reg, p2_reg, p3_reg, p4_reg;
    sample_t    f1r_reg, f1i_reg;
    sample_t    dr_reg, di_reg;
    logic       done_reg, done_next;
    logic [1:0] kind_reg;              // result type
    sample_t    or_reg, oi_reg;

    logic        we;
    logic [7:0]  ram_addr;
    logic [31:0] wdata, rdata;

    rfft_ram #(.Width(32), .Depth(Words)) u_ram (
        .clk(clk), .we(we), .addr(ram_addr), .wdata(wdata), .rdata(rdata)
    );

    // bit reverse of idx
    logic [7:0] rev;
    always_comb
    begin
        for (int b = 0; b < 8; b++)
            rev[b] = idx_reg[7-b];
    end

    // butterfly addressing for radix pass: len = 1<<pass
    logic [7:0] lenm, bfa, bfb, mirror;
    logic [7:0] phase;
    always_comb
    begin
        lenm   = (8'd1 << pass_reg[2:0]) - 8'd1;
        // insert a zero at bit position pass into 7-bit counter
        bfa    = ((idx_reg & ~lenm) << 1) | (idx_reg & lenm);
        bfb    = bfa | (8'd1 << pass_reg[2:0]);
        phase  = (idx_reg & lenm) << (4'd8 - {1'b0, pass_reg[2:0]});
        mirror = 8'd0 - (idx_reg + 8'd1);
    end

    logic split;
    assign split = pass_reg[3];

    sample_t wr, wi;
    always_comb
    begin
        if (split) begin
            wr = sine_at(9'({1'b0, idx_reg} + 9'd1 + 9'd256));
            wi = -sine_at(9'({1'b0, idx_reg} + 9'd1 + 9'd128));
        end else begin
            wr = sine_at(9'({1'b0, phase} + 9'd128));
            wi = -sine_at({1'b0, phase});
        end
    end

    sample_t rd_re, rd_im;
    assign rd_re = rdata[31:16];
    assign rd_im = rdata[15:0];

    // floor(-im/2); the negation is taken one bit wider so -(-32768) halves to 16384
    sample_t half_neg_im;
    assign half_neg_im = sample_t'((-(17'(rd_im))) >>> 1);

    // operand x,y into shared multiplier set
    sample_t xr, xi;
    always_comb
    begin
        if (split) begin
            xr = dr_reg;
            xi = di_reg;
        end else begin
            xr = br_reg;
            xi = bi_reg;
        end
    end

    sample_t tr, ti;
    assign tr = p1_reg - p2_reg;
    assign ti = p3_reg + p4_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pass_next  = pass_reg;
        addr_next  = addr_reg;
        done_next  = 1'b0;
        we         = 1'b0;
        ram_addr   = addr_reg;
        wdata      = {ar_reg, ai_reg};
        unique case (state_reg)
            S_IDLE: begin
                ram_addr = word_index;
                wdata    = {in_real, in_imag};
                if (start) begin
                    addr_next = word_index;
                    unique case (opcode)
                        OP_WRITE: begin
                            we        = 1'b1;
                            state_next = S_DONE;
                        end
                        OP_READ:  state_next = S_RD;
                        OP_XFORM: begin
                            idx_next   = 8'd1;
                            state_next = S_BA;
                        end
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_RD:  state_next = S_RDO;
            S_RDO: state_next = S_DONE;
            S_BA: begin
                ram_addr = idx_reg;
                if (rev > idx_reg)
                    state_next = S_BB;
                else if (idx_reg == 8'd255) begin
                    idx_next = 8'd0; pass_next = 4'd0; state_next = S_FA;
                end else
                    idx_next = idx_reg + 8'd1;
            end
            S_BB: begin ram_addr = rev; state_next = S_BC; end
            S_BC: begin ram_addr = rev; state_next = S_BD; end
            S_BD: begin
                ram_addr = idx_reg; we = 1'b1; wdata = rdata; state_next = S_BE;
            end
            S_BE: begin
                ram_addr = rev; we = 1'b1; wdata = {ar_reg, ai_reg};
                if (idx_reg == 8'd255) begin
                    idx_next = 8'd0; pass_next = 4'd0; state_next = S_FA;
                end else begin
                    idx_next = idx_reg + 8'd1; state_next = S_BA;
                end
            end
            S_FA: begin
                ram_addr = split ? idx_reg + 8'd1 : bfa;
                state_next = S_FB;
            end
            S_FB: begin ram_addr = split ? mirror : bfb; state_next = S_FC; end
            S_FC: state_next = S_FD;
            S_FD: state_next = S_FE;
            S_FE: state_next = S_FF;
            S_FF: begin
                ram_addr = split ? idx_reg + 8'd1 : bfa;
                we = 1'b1;
                wdata = split ? {f1r_reg + tr, f1i_reg + ti} : {ar_reg + tr, ai_reg + ti};
                state_next = S_FG;
            end
            S_FG: begin
                ram_addr = split ? mirror : bfb;
                we = 1'b1;
                wdata = split ? {f1r_reg - tr, ti - f1i_reg} : {ar_reg - tr, ai_reg - ti};
                state_next = S_FA;
                if ((split && idx_reg == 8'd126) || (!split && idx_reg == 8'd127)) begin
                    idx_next = 8'd0;
                    if (split)
                        state_next = S_DONE;
                    else
                        pass_next = pass_reg + 4'd1;
                end else
                    idx_next = idx_reg + 8'd1;
            end
            S_DONE: begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            idx_reg   <= 8'd0;
            pass_reg  <= 4'd0;
            addr_reg  <= 8'd0;
            done_reg  <= 1'b0;
            kind_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pass_reg  <= pass_next;
            addr_reg  <= addr_next;
            done_reg  <= done_next;
            if (state_reg == S_IDLE && start)
                kind_reg <= opcode;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RDO) begin
            or_reg <= rd_re;
            oi_reg <= rd_im;
        end
        if (state_reg == S_BB) begin
            ar_reg <= rd_re; ai_reg <= rd_im;
        end
        if (state_reg == S_FB) begin
            ar_reg <= rd_re >>> 1;
            ai_reg <= rd_im >>> 1;
        end
        if (state_reg == S_FC) begin
            br_reg <= rd_re >>> 1;
            if (split) begin
                bi_reg  <= half_neg_im;
                f1r_reg <= ar_reg + (rd_re >>> 1);
                f1i_reg <= ai_reg + half_neg_im;
                dr_reg  <= ar_reg - (rd_re >>> 1);
                di_reg  <= ai_reg - half_neg_im;
            end else begin
                bi_reg <= rd_im >>> 1;
            end
        end
        if (state_reg == S_FE) begin
            p1_reg <= qmul(wr, xr);
            p2_reg <= qmul(wi, xi);
            p3_reg <= qmul(wr, xi);
            p4_reg <= qmul(wi, xr);
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign out_real    = (done_reg && kind_reg == OP_READ) ? or_reg : '0;
    assign out_imag    = (done_reg && kind_reg == OP_READ) ? oi_reg : '0;
    assign shift_total = (done_reg && kind_reg == OP_XFORM) ? 4'(Log2Points) : 4'd0;

    `RFFT_ASSERT_IMP(a_done_idle, done, !busy, "result while busy")
    `RFFT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not go busy")
    `RFFT_ASSERT_IMP(a_no_write_read, state_reg == S_RD || state_reg == S_RDO, !we,
        "write during read")
    `RFFT_ASSERT_IMP(a_pass_range, busy, pass_reg <= 4'd8, "pass counter out of range")
endmodule

FILE: rtl/rfft_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module rfft_ram #(
    parameter int Width = 32,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
